/* rtl/lmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lmt_pkg;

   localparam int ENTRIES_DEFAULT      = 64;
   localparam int RECORD_WIDTH_DEFAULT = 64;
   localparam logic [6:0] ENTRIES_IN_USE_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_INSERT     = 2'd0,
      OP_FIND_FIRST = 2'd1,
      OP_FIND_NEXT  = 2'd2,
      OP_TOUCH      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LOAD,
      ST_SCAN,
      ST_FETCH,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

/* rtl/lmt_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module lmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/lru_memo_table.sv */
`timescale 1ns / 1ps
`default_nettype none
// Flow: insert and find first scan at once; find next and touch first read the entry's
//   rank (PREP, LOAD); a find hit or valid touch then reads the data RAM (FETCH); a miss
//   of find next or touch skips the scan. Throughput: one item at a time, set by the rank
//   scan that reads the tag RAM one entry per cycle; a stalled result holds it.
// Reset (synchronous, active high): table empty, next id 1, no cursor, limit 64,
//   no result pending. RAM contents are not cleared.
module lru_memo_table #(
   parameter int ENTRIES      = lmt_pkg::ENTRIES_DEFAULT,
   parameter int RECORD_WIDTH = lmt_pkg::RECORD_WIDTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request items
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_op,
   input  wire logic [31:0] req_pc,
   input  wire logic [31:0] req_next_pc,
   input  wire logic [63:0] req_payload,
   input  wire logic [5:0]  req_entry_index,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_hit,
   output logic [5:0]       rsp_found_index,
   output logic [31:0]      rsp_entry_id,
   output logic [31:0]      rsp_found_next_pc,
   output logic [63:0]      rsp_found_payload,
   output logic [31:0]      rsp_use_count,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_entries_in_use
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int TAG_W = 32 + IDX_W;                    // {key, rank}
   localparam int DAT_W = 32 + RECORD_WIDTH + 32 + 32;   // {next_pc, record, id, count}

   // ---------------------------------------------------------------- state
   lmt_pkg::state_type state_ff, state_in;
   lmt_pkg::op_type    op_ff, op_in;

   logic [31:0]             pc_ff, pc_in;
   logic [31:0]             npc_ff, npc_in;
   logic [RECORD_WIDTH-1:0] rec_ff, rec_in;
   logic [IDX_W-1:0]        tgt_ff, tgt_in;        // entry concerned (victim, best, touched)
   logic                    hit_ff, hit_in;
   logic                    evict_ff, evict_in;
   logic [IDX_W-1:0]        old_rank_ff, old_rank_in; // touched rank or find-next floor
   logic                    best_valid_ff, best_valid_in;
   logic [IDX_W-1:0]        best_rank_ff, best_rank_in;
   logic [CNT_W-1:0]        scan_cnt_ff, scan_cnt_in;
   logic                    p_valid_ff, p_valid_in;
   logic [IDX_W-1:0]        p_addr_ff, p_addr_in;

   logic [CNT_W-1:0] filled_ff, filled_in;
   logic [31:0]      fresh_ff, fresh_in;
   logic             cursor_valid_ff, cursor_valid_in;
   logic [IDX_W-1:0] cursor_ff, cursor_in;
   logic [6:0]       eiu_ff, eiu_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [5:0]              rsp_index_ff, rsp_index_in;
   logic [31:0]             rsp_id_ff, rsp_id_in;
   logic [31:0]             rsp_npc_ff, rsp_npc_in;
   logic [63:0]             rsp_rec_ff, rsp_rec_in;
   logic [31:0]             rsp_count_ff, rsp_count_in;

   // ---------------------------------------------------------------- RAMs
   logic             a_wr_en;
   logic [IDX_W-1:0] a_wr_addr, a_rd_addr;
   logic [TAG_W-1:0] a_wr_data, a_rd_data;
   logic             b_wr_en;
   logic [DAT_W-1:0] b_wr_data, b_rd_data;

   lmt_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   lmt_ram #(.WIDTH(DAT_W), .DEPTH(ENTRIES)) u_data_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (tgt_ff),
      .wr_data (b_wr_data),
      .rd_addr (tgt_ff),
      .rd_data (b_rd_data)
   );

   logic [31:0]       a_key;
   logic [IDX_W-1:0]  a_rank;
   logic [31:0]             b_npc, b_id, b_count;
   logic [RECORD_WIDTH-1:0] b_rec;

   assign a_key  = a_rd_data[TAG_W-1:IDX_W];
   assign a_rank = a_rd_data[IDX_W-1:0];
   assign {b_npc, b_rec, b_id, b_count} = b_rd_data;

   // ---------------------------------------------------------------- limit
   logic [CNT_W-1:0] limit;
   always_comb begin
      if (eiu_ff == 7'd0) begin
         limit = CNT_W'(1);
      end else if (32'(eiu_ff) > 32'(ENTRIES)) begin
         limit = CNT_W'(ENTRIES);
      end else begin
         limit = CNT_W'(eiu_ff);
      end
   end

   logic accept, out_free, scan_issue, scan_done, touch_ok, cursor_ok;

   assign accept     = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign scan_issue = scan_cnt_ff < filled_ff;
   assign scan_done  = !scan_issue && !p_valid_ff;
   assign touch_ok   = 32'(req_entry_index) < 32'(filled_ff);
   assign cursor_ok  = cursor_valid_ff && (CNT_W'(cursor_ff) < filled_ff);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lmt_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (lmt_pkg::op_type'(req_op))
                  lmt_pkg::OP_INSERT,
                  lmt_pkg::OP_FIND_FIRST: state_in = lmt_pkg::ST_SCAN;
                  lmt_pkg::OP_FIND_NEXT:
                     state_in = cursor_ok ? lmt_pkg::ST_PREP : lmt_pkg::ST_OUT;
                  lmt_pkg::OP_TOUCH:
                     state_in = touch_ok ? lmt_pkg::ST_PREP : lmt_pkg::ST_OUT;
                  default: state_in = lmt_pkg::ST_OUT;
               endcase
            end
         end
         lmt_pkg::ST_PREP: state_in = lmt_pkg::ST_LOAD;
         lmt_pkg::ST_LOAD: state_in = lmt_pkg::ST_SCAN;
         lmt_pkg::ST_SCAN: begin
            if (scan_done) begin
               unique case (op_ff)
                  lmt_pkg::OP_INSERT: state_in = lmt_pkg::ST_OUT;
                  lmt_pkg::OP_TOUCH:  state_in = lmt_pkg::ST_FETCH;
                  default:
                     state_in = best_valid_ff ? lmt_pkg::ST_FETCH : lmt_pkg::ST_OUT;
               endcase
            end
         end
         lmt_pkg::ST_FETCH: state_in = lmt_pkg::ST_OUT;
         lmt_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = lmt_pkg::ST_IDLE;
            end
         end
         default: state_in = lmt_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      req_ready = (state_ff == lmt_pkg::ST_IDLE);
      csr_ready = 1'b1;

      op_in = op_ff;  pc_in = pc_ff;  npc_in = npc_ff;  rec_in = rec_ff;
      tgt_in = tgt_ff;  hit_in = hit_ff;  evict_in = evict_ff;
      old_rank_in = old_rank_ff;
      best_valid_in = best_valid_ff;  best_rank_in = best_rank_ff;
      scan_cnt_in = scan_cnt_ff;  p_valid_in = 1'b0;  p_addr_in = p_addr_ff;
      filled_in = filled_ff;  fresh_in = fresh_ff;
      cursor_valid_in = cursor_valid_ff;  cursor_in = cursor_ff;
      eiu_in = (csr_valid && csr_ready) ? csr_entries_in_use : eiu_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hit_in = rsp_hit_ff;  rsp_index_in = rsp_index_ff;  rsp_id_in = rsp_id_ff;
      rsp_npc_in = rsp_npc_ff;  rsp_rec_in = rsp_rec_ff;  rsp_count_in = rsp_count_ff;

      a_wr_en = 1'b0;  a_wr_addr = p_addr_ff;  a_wr_data = a_rd_data;
      a_rd_addr = scan_cnt_ff[IDX_W-1:0];
      b_wr_en = 1'b0;  b_wr_data = b_rd_data;

      // latch the item and set up the scan
      if (accept) begin
         op_in         = lmt_pkg::op_type'(req_op);
         pc_in         = req_pc;
         npc_in        = req_next_pc;
         rec_in        = req_payload[RECORD_WIDTH-1:0];
         scan_cnt_in   = '0;
         best_valid_in = 1'b0;
         evict_in      = filled_ff >= limit;
         unique case (lmt_pkg::op_type'(req_op))
            lmt_pkg::OP_INSERT: begin
               tgt_in = filled_ff[IDX_W-1:0];
               hit_in = 1'b1;
            end
            lmt_pkg::OP_FIND_FIRST: hit_in = 1'b0;
            lmt_pkg::OP_FIND_NEXT: begin
               tgt_in = cursor_ff;
               hit_in = 1'b0;
            end
            lmt_pkg::OP_TOUCH: begin
               tgt_in = IDX_W'(req_entry_index);
               hit_in = touch_ok;
            end
            default: hit_in = 1'b0;
         endcase
      end

      // read the rank of the touched or cursor entry
      if (state_ff == lmt_pkg::ST_PREP) begin
         a_rd_addr = tgt_ff;
      end
      if (state_ff == lmt_pkg::ST_LOAD) begin
         old_rank_in = a_rank;
      end

      // scan: issue one read per cycle, process the returned tag in the cycle after the read
      if (state_ff == lmt_pkg::ST_SCAN) begin
         if (scan_issue) begin
            p_valid_in  = 1'b1;
            p_addr_in   = scan_cnt_ff[IDX_W-1:0];
            scan_cnt_in = scan_cnt_ff + CNT_W'(1);
         end
         if (p_valid_ff) begin
            unique case (op_ff)
               lmt_pkg::OP_INSERT: begin
                  // least recent entry holds rank filled-1; it is rewritten at the end
                  if (evict_ff && (CNT_W'(a_rank) == filled_ff - CNT_W'(1))) begin
                     tgt_in = p_addr_ff;
                  end else begin
                     a_wr_en   = 1'b1;
                     a_wr_data = {a_key, a_rank + IDX_W'(1)};
                  end
               end
               lmt_pkg::OP_TOUCH: begin
                  if (p_addr_ff == tgt_ff) begin
                     a_wr_en   = 1'b1;
                     a_wr_data = {a_key, {IDX_W{1'b0}}};
                  end else if (a_rank < old_rank_ff) begin
                     a_wr_en   = 1'b1;
                     a_wr_data = {a_key, a_rank + IDX_W'(1)};
                  end
               end
               default: begin
                  if ((a_key == pc_ff)
                      && ((op_ff == lmt_pkg::OP_FIND_FIRST) || (a_rank > old_rank_ff))
                      && (!best_valid_ff || (a_rank < best_rank_ff))) begin
                     best_valid_in = 1'b1;
                     best_rank_in  = a_rank;
                     tgt_in        = p_addr_ff;
                  end
               end
            endcase
         end
         if (scan_done && ((op_ff == lmt_pkg::OP_FIND_FIRST)
                           || (op_ff == lmt_pkg::OP_FIND_NEXT))) begin
            hit_in = best_valid_ff;
         end
      end

      // commit and load the result register once it is free
      if ((state_ff == lmt_pkg::ST_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_index_in = hit_ff ? 6'(tgt_ff) : 6'd0;
         rsp_id_in    = '0;
         rsp_npc_in   = '0;
         rsp_rec_in   = '0;
         rsp_count_in = '0;
         unique case (op_ff)
            lmt_pkg::OP_INSERT: begin
               rsp_id_in  = fresh_ff;
               rsp_npc_in = npc_ff;
               rsp_rec_in = 64'(rec_ff);
               a_wr_en    = 1'b1;
               a_wr_addr  = tgt_ff;
               a_wr_data  = {pc_ff, {IDX_W{1'b0}}};
               b_wr_en    = 1'b1;
               b_wr_data  = {npc_ff, rec_ff, fresh_ff, 32'd0};
               fresh_in   = fresh_ff + 32'd1;
               if (!evict_ff) begin
                  filled_in = filled_ff + CNT_W'(1);
               end
            end
            lmt_pkg::OP_TOUCH: begin
               if (hit_ff) begin
                  rsp_id_in    = b_id;
                  rsp_npc_in   = b_npc;
                  rsp_rec_in   = 64'(b_rec);
                  rsp_count_in = b_count + 32'd1;
                  b_wr_en      = 1'b1;
                  b_wr_data    = {b_npc, b_rec, b_id, b_count + 32'd1};
               end
            end
            default: begin
               cursor_valid_in = hit_ff;
               cursor_in       = hit_ff ? tgt_ff : '0;
               if (hit_ff) begin
                  rsp_id_in    = b_id;
                  rsp_npc_in   = b_npc;
                  rsp_rec_in   = 64'(b_rec);
                  rsp_count_in = b_count;
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= lmt_pkg::ST_IDLE;
         filled_ff       <= '0;
         fresh_ff        <= 32'd1;
         cursor_valid_ff <= 1'b0;
         cursor_ff       <= '0;
         eiu_ff          <= lmt_pkg::ENTRIES_IN_USE_RESET;
         rsp_valid_ff    <= 1'b0;
         p_valid_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         filled_ff       <= filled_in;
         fresh_ff        <= fresh_in;
         cursor_valid_ff <= cursor_valid_in;
         cursor_ff       <= cursor_in;
         eiu_ff          <= eiu_in;
         rsp_valid_ff    <= rsp_valid_in;
         p_valid_ff      <= p_valid_in;
      end
      op_ff         <= op_in;
      pc_ff         <= pc_in;
      npc_ff        <= npc_in;
      rec_ff        <= rec_in;
      tgt_ff        <= tgt_in;
      hit_ff        <= hit_in;
      evict_ff      <= evict_in;
      old_rank_ff   <= old_rank_in;
      best_valid_ff <= best_valid_in;
      best_rank_ff  <= best_rank_in;
      scan_cnt_ff   <= scan_cnt_in;
      p_addr_ff     <= p_addr_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_npc_ff    <= rsp_npc_in;
      rsp_rec_ff    <= rsp_rec_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_found_index   = rsp_index_ff;
   assign rsp_entry_id      = rsp_id_ff;
   assign rsp_found_next_pc = rsp_npc_ff;
   assign rsp_found_payload = rsp_rec_ff;
   assign rsp_use_count     = rsp_count_ff;

endmodule
`default_nettype wire

/* rtl/lmt_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module lmt_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_hit,
   input wire logic [5:0]  rsp_found_index,
   input wire logic [31:0] rsp_entry_id,
   input wire logic [31:0] rsp_found_next_pc,
   input wire logic [63:0] rsp_found_payload,
   input wire logic [31:0] rsp_use_count
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_found_index) && $stable(rsp_entry_id))
      else $error("stalled result changed");

   // a miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_found_index == 6'd0 && rsp_entry_id == 32'd0
         && rsp_found_next_pc == 32'd0 && rsp_found_payload == 64'd0
         && rsp_use_count == 32'd0)
      else $error("miss with nonzero fields");

   // one item at a time: no accept right after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

   // drop any result on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind lru_memo_table lmt_checker u_lmt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_hit           (rsp_hit),
   .rsp_found_index   (rsp_found_index),
   .rsp_entry_id      (rsp_entry_id),
   .rsp_found_next_pc (rsp_found_next_pc),
   .rsp_found_payload (rsp_found_payload),
   .rsp_use_count     (rsp_use_count)
);
`default_nettype wire
